// ----- src/ifp_pkg.sv -----
// Shared types, constants and a helper function for the IMU frame parser.
package ifp_pkg;

  localparam int unsigned FRAME_LEN = 11;
  localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);
  localparam logic [7:0] HEADER_RESET = 8'h55;

  localparam logic [7:0] KIND_ACCEL = 8'h51;
  localparam logic [7:0] KIND_GYRO = 8'h52;
  localparam logic [7:0] KIND_ANGLE = 8'h53;
  localparam logic [7:0] KIND_MAG = 8'h54;
  localparam logic [7:0] KIND_PRESS = 8'h56;
  localparam logic [7:0] KIND_QUAT = 8'h59;

  typedef enum logic [1:0] {
    ST_GOOD         = 2'd0,
    ST_BAD_SUM      = 2'd1,
    ST_UNKNOWN_KIND = 2'd2
  } ifp_status_t;

  typedef struct packed {
    logic [31:0]        fail_count;
    logic [31:0]        good_count;
    logic signed [31:0] height_raw;
    logic [31:0]        pressure_raw;
    logic signed [15:0] word_d;
    logic signed [15:0] word_c;
    logic signed [15:0] word_b;
    logic signed [15:0] word_a;
    logic [7:0]         frame_kind;
    ifp_status_t        frame_status;
  } ifp_result_t;

  function automatic logic kind_known(input logic [7:0] kind);
    logic known;
    case (kind) inside
      [KIND_ACCEL:KIND_MAG], KIND_PRESS, KIND_QUAT: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

// ----- src/ifp_frame_decode.sv -----
// Checksum check, type check and field decode of one completed frame.
module ifp_frame_decode (
  input  logic [9:1][7:0]      frame_bytes,
  input  logic [7:0]           run_sum,
  input  logic [7:0]           check_byte,
  input  logic [31:0]          good_in,
  input  logic [31:0]          fail_in,
  output ifp_pkg::ifp_result_t result,
  output logic                 sum_ok
);
  import ifp_pkg::*;

  always_comb begin
    sum_ok = (run_sum == check_byte);
    result = '0;
    result.frame_kind = frame_bytes[1];
    if (!sum_ok) begin
      result.frame_status = ST_BAD_SUM;
    end else if (kind_known(frame_bytes[1])) begin
      result.frame_status = ST_GOOD;
    end else begin
      result.frame_status = ST_UNKNOWN_KIND;
    end
    if (sum_ok) begin
      result.word_a = {frame_bytes[3], frame_bytes[2]};
      result.word_b = {frame_bytes[5], frame_bytes[4]};
      result.word_c = {frame_bytes[7], frame_bytes[6]};
      result.word_d = {frame_bytes[9], frame_bytes[8]};
      result.pressure_raw = {frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2]};
      result.height_raw = {frame_bytes[9], frame_bytes[8], frame_bytes[7], frame_bytes[6]};
    end
    result.good_count = good_in + 32'(sum_ok);
    result.fail_count = fail_in + 32'(!sum_ok);
  end

endmodule

// ----- src/imu_frame_parser_checksum_unit.sv -----
// Top level of the IMU frame parser with header hunt and 8-bit sum checksum.
//
// The input stream carries one received byte per item in in_tdata and a resync
// flag in in_tuser. While hunting, the block waits for a byte equal to the
// header register, then collects ten more bytes into an 11-byte frame. At the
// last byte it compares the 8-bit running sum of bytes 0 to 9 with byte 10 and
// emits one result item on the output stream: status and type byte in
// out_tuser, decoded words, pressure, height and both frame counts in
// out_tdata. A failed frame carries zeros in its data fields. Resync drops a
// partial frame and the byte that carries it.
// An item is registered at the input and processed from there into the output
// register, so a result becomes valid when that register loads it, after the edge
// that accepts its last byte. One byte per cycle is sustained while the
// receiver takes each result. When the receiver stalls with a result pending,
// processing halts and in_tready falls once the input register is also full.
// The header register is written through the cfg channel, which is always
// ready. Reset clears the counts, sets the header to 0x55 and starts hunting.
module imu_frame_parser_checksum_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // rx_byte[7:0]
  input  logic [0:0]   in_tuser,   // resync[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // word_a, word_b, word_c, word_d, pressure_raw,
                                   // height_raw, good_count, fail_count
  output logic [9:0]   out_tuser,  // frame_status[1:0], frame_kind[9:2]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import ifp_pkg::*;

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_resync_r;
  logic [7:0]      header_r;
  logic            collecting_r;
  logic [3:0]      pos_r;
  logic [7:0]      sum_r;
  logic [9:1][7:0] store_r;
  logic [31:0]     good_r;
  logic [31:0]     bad_r;
  logic            out_valid_r;
  ifp_result_t     out_data_r;

  logic            advance;
  logic            process;
  logic            emit;
  logic            sum_ok;
  ifp_result_t     dec_result;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign process   = s1_valid_r && advance;
  assign emit      = process && !s1_resync_r && collecting_r && (pos_r == LAST_POS);
  assign cfg_ready = 1'b1;

  ifp_frame_decode u_decode (
    .frame_bytes (store_r),
    .run_sum     (sum_r),
    .check_byte  (s1_byte_r),
    .good_in     (good_r),
    .fail_in     (bad_r),
    .result      (dec_result),
    .sum_ok      (sum_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r   <= in_tdata;
      s1_resync_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
      sum_r        <= '0;
      good_r       <= '0;
      bad_r        <= '0;
    end else if (process) begin
      if (s1_resync_r) begin
        collecting_r <= 1'b0;
        pos_r        <= '0;
        sum_r        <= '0;
      end else if (!collecting_r) begin
        if (s1_byte_r == header_r) begin
          collecting_r <= 1'b1;
          pos_r        <= 4'd1;
          sum_r        <= s1_byte_r;
        end
      end else if (pos_r == LAST_POS) begin
        collecting_r <= 1'b0;
        pos_r        <= '0;
        sum_r        <= '0;
        good_r       <= dec_result.good_count;
        bad_r        <= dec_result.fail_count;
      end else begin
        pos_r <= pos_r + 4'd1;
        sum_r <= sum_r + s1_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && !s1_resync_r && collecting_r) begin
      for (int i = 1; i <= 9; i++) begin
        if (pos_r == 4'(i)) begin
          store_r[i] <= s1_byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= dec_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_data_r.frame_kind, out_data_r.frame_status};
  assign out_tdata  = {out_data_r.fail_count, out_data_r.good_count,
                       out_data_r.height_raw, out_data_r.pressure_raw,
                       out_data_r.word_d, out_data_r.word_c,
                       out_data_r.word_b, out_data_r.word_a};

  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !collecting_r |-> (pos_r == '0) && (sum_r == '0))
    else $error("hunting with nonzero position or sum");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (pos_r >= 4'd1) && (pos_r <= LAST_POS))
    else $error("frame position out of range");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("frame end did not load a result");

  a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !sum_ok |=> (bad_r == $past(bad_r) + 32'd1) && (good_r == $past(good_r)))
    else $error("failed frame not counted correctly");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit && sum_ok |=> (good_r == $past(good_r) + 32'd1) && (bad_r == $past(bad_r)))
    else $error("good frame not counted correctly");

endmodule

// ----- bench/tb_imu_frame_parser_checksum_unit.sv -----
// Self-checking testbench for the IMU frame parser with scoreboard prediction.
module tb_imu_frame_parser_checksum_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ifp_pkg::*;

  class frame_scoreboard;
    logic [7:0]  header;
    bit          collecting;
    int unsigned pos;
    logic [7:0]  frame[FRAME_LEN];
    logic [7:0]  csum;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    ifp_result_t expected[$];
    int          errors;

    function new();
      header = HEADER_RESET;
      collecting = 1'b0;
      pos = 0;
      csum = '0;
      good_frames = '0;
      bad_frames = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_item(input logic [7:0] rx, input logic resync);
      ifp_result_t r;
      bit known;
      if (resync) begin
        collecting = 1'b0;
        pos = 0;
        csum = '0;
        return;
      end
      if (!collecting) begin
        if (rx == header) begin
          frame[0] = rx;
          csum = rx;
          pos = 1;
          collecting = 1'b1;
        end
        return;
      end
      frame[pos] = rx;
      if (pos < LAST_POS) begin
        csum = csum + rx;
        pos++;
        return;
      end
      r = '0;
      r.frame_kind = frame[1];
      if (csum == rx) begin
        good_frames++;
        known = (frame[1] >= KIND_ACCEL && frame[1] <= KIND_MAG) ||
                frame[1] == KIND_PRESS || frame[1] == KIND_QUAT;
        r.frame_status = known ? ST_GOOD : ST_UNKNOWN_KIND;
        r.word_a = {frame[3], frame[2]};
        r.word_b = {frame[5], frame[4]};
        r.word_c = {frame[7], frame[6]};
        r.word_d = {frame[9], frame[8]};
        r.pressure_raw = {frame[5], frame[4], frame[3], frame[2]};
        r.height_raw = {frame[9], frame[8], frame[7], frame[6]};
      end else begin
        bad_frames++;
        r.frame_status = ST_BAD_SUM;
      end
      r.good_count = good_frames;
      r.fail_count = bad_frames;
      expected.push_back(r);
      collecting = 1'b0;
      pos = 0;
      csum = '0;
    endfunction

    function void compare(input string name, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input logic [191:0] d, input logic [9:0] u);
      ifp_result_t e;
      if (expected.size() == 0) begin
        $error("result item arrived with no frame pending");
        errors++;
        return;
      end
      e = expected.pop_front();
      compare("frame_status", 32'(e.frame_status), 32'(u[1:0]));
      compare("frame_kind", 32'(e.frame_kind), 32'(u[9:2]));
      compare("word_a", 32'($unsigned(e.word_a)), 32'(d[15:0]));
      compare("word_b", 32'($unsigned(e.word_b)), 32'(d[31:16]));
      compare("word_c", 32'($unsigned(e.word_c)), 32'(d[47:32]));
      compare("word_d", 32'($unsigned(e.word_d)), 32'(d[63:48]));
      compare("pressure_raw", e.pressure_raw, d[95:64]);
      compare("height_raw", $unsigned(e.height_raw), d[127:96]);
      compare("good_count", e.good_count, d[159:128]);
      compare("fail_count", e.fail_count, d[191:160]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // rx_byte[7:0]
  logic [0:0]   in_tuser;   // resync[0]
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // word_a, word_b, word_c, word_d, pressure_raw,
                            // height_raw, good_count, fail_count
  logic [9:0]   out_tuser;  // frame_status[1:0], frame_kind[9:2]
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_data;

  frame_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     byte_count = 0;

  localparam logic [7:0] KNOWN_KINDS[6] = '{KIND_ACCEL, KIND_GYRO, KIND_ANGLE,
                                            KIND_MAG, KIND_PRESS, KIND_QUAT};

  imu_frame_parser_checksum_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
    end
  end

  task automatic send_item(input logic [7:0] rx, input logic flag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = 8'($urandom);
      in_tuser = 1'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = rx;
    in_tuser = flag;
    do @(posedge clk); while (!in_tready);
    sb.note_item(rx, flag);
    if (!flag) begin
      byte_count++;
    end
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return sb.header;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] kind, input bit bad_sum, input int cut,
                            input logic [7:0] fixed[], input bit use_fixed);
    logic [7:0] b;
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == cut) begin
        send_item(8'($urandom), 1'b1);
        return;
      end
      if (i == 0) begin
        b = sb.header;
      end else if (i == 1) begin
        b = kind;
      end else if (i == LAST_POS) begin
        b = bad_sum ? s ^ 8'($urandom_range(1, 255)) : s;
      end else begin
        b = use_fixed ? fixed[i - 2] : data_byte();
      end
      s = s + b;
      send_item(b, 1'b0);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    for (int i = 0; i < 20000 && sb.pending() != 0; i++) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.header = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("FAIL imu_frame_parser_checksum_unit");
    $finish;
  end

  initial begin
    logic [7:0]  edge_bytes[];
    logic [7:0]  ones[];
    logic [7:0]  hdr_plan[4];
    logic [7:0]  kind;
    int unsigned start;
    int unsigned pick;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: resync while hunting, a good frame carrying the header byte as
    // data plus sign extremes, and a failed frame of an unknown type.
    edge_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, HEADER_RESET, 8'hFF, 8'h01, 8'h80};
    ones = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_item(HEADER_RESET, 1'b1);
    send_frame(KIND_ACCEL, 1'b0, FRAME_LEN, edge_bytes, 1'b1);
    send_frame(8'hAB, 1'b1, FRAME_LEN, ones, 1'b1);
    drain();

    hdr_plan = '{8'h00, 8'hFF, 8'($urandom), HEADER_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_header(hdr_plan[ph]);
      send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 6 : 0;
      recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 6 : 0;
      start = byte_count;
      while (byte_count - start < 290) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          kind = ($urandom_range(2) == 0) ? 8'($urandom) : KNOWN_KINDS[$urandom_range(5)];
          send_frame(kind, $urandom_range(4) == 0,
                     ($urandom_range(9) == 0) ? $urandom_range(1, 10) : FRAME_LEN,
                     ones, 1'b0);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
          if (sb.collecting && $urandom_range(1) == 0) begin
            send_item(8'($urandom), 1'b1);
          end
        end else begin
          send_item(8'($urandom), 1'b1);
        end
      end
    end

    drain();
    if (sb.pending() != 0) begin
      $error("%0d result items never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS imu_frame_parser_checksum_unit");
    end else begin
      $display("FAIL imu_frame_parser_checksum_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ifp_pkg.sv
src/ifp_frame_decode.sv
src/imu_frame_parser_checksum_unit.sv
bench/tb_imu_frame_parser_checksum_unit.sv
